// ===== rtl/core/nsd_pkg.sv =====
package nsd_pkg;

    // Character codes used by the framer
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    // 'A' - 10: subtracting it maps 'A'..'F' onto 10..15
    localparam logic [7:0] CH_A_LESS_TEN = 8'h37;

    // Configuration port
    localparam int CFG_DATA_W  = 40;
    localparam int CFG_INDEX_W = 1;
    localparam int MATCH_LEN_W = 3;

    // Reset address is "GPGGA", first character in the top used byte
    localparam logic [CFG_DATA_W-1:0]  MATCH_ADDRESS_RESET = 40'h47_5047_4741;
    localparam logic [MATCH_LEN_W-1:0] MATCH_LENGTH_RESET  = 3'd5;

    // Largest address length that match_length can name
    localparam int MATCH_CHARS = 7;

    // Result field widths
    localparam int ADDR_LEN_W = 3;
    localparam int PAY_LEN_W  = 7;
    localparam int COUNT_W    = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MATCH_ADDRESS = 1'b0,
        CFG_MATCH_LENGTH  = 1'b1
    } nsd_cfg_idx_t;

    typedef enum logic [4:0] {
        PH_HUNT = 5'b00001,
        PH_ADDR = 5'b00010,
        PH_DATA = 5'b00100,
        PH_SUM1 = 5'b01000,
        PH_SUM2 = 5'b10000
    } nsd_phase_t;

    // One finished sentence, from the parser to the result register
    typedef struct packed {
        logic                  emit;
        logic                  address_is_match;
        logic [ADDR_LEN_W-1:0] address_length;
        logic [PAY_LEN_W-1:0]  payload_length;
        logic                  checksum_checked;
        logic [COUNT_W-1:0]    sentence_count;
    } nsd_result_t;

    // Uppercase hex digit decode, modulo 256 like the byte arithmetic
    function automatic logic [7:0] hex_value(input logic [7:0] b);
        logic [7:0] v;
        if (b <= CH_NINE)
            v = b - CH_ZERO;
        else
            v = b - CH_A_LESS_TEN;
        return v;
    endfunction

endpackage

// ===== rtl/core/nsd_byte_if.sv =====
interface nsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/nsd_result_if.sv =====
interface nsd_result_if;
    logic        valid;
    logic        ready;
    logic        address_is_match;
    logic [2:0]  address_length;
    logic [6:0]  payload_length;
    logic        checksum_checked;
    logic [31:0] sentence_count;

    modport source (
        output valid, output address_is_match, output address_length,
        output payload_length, output checksum_checked, output sentence_count,
        input  ready
    );
    modport sink (
        input  valid, input address_is_match, input address_length,
        input  payload_length, input checksum_checked, input sentence_count,
        output ready
    );
endinterface

// ===== rtl/core/nsd_ram.sv =====
module nsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/nsd_match.sv =====
module nsd_match #(
    parameter int ADDRESS_MAX = 8
) (
    input  logic [ADDRESS_MAX-1:0][7:0]           store,
    input  logic [$clog2(ADDRESS_MAX)-1:0]        count,
    input  logic [nsd_pkg::CFG_DATA_W-1:0]        match_address,
    input  logic [nsd_pkg::MATCH_LEN_W-1:0]       match_length,
    output logic                                  hit
);
    import nsd_pkg::*;

    localparam int ACNT_W = $clog2(ADDRESS_MAX);
    localparam int CMP_W  = (ACNT_W > MATCH_LEN_W) ? ACNT_W : MATCH_LEN_W;
    // Stored characters that a configured length can ever reach
    localparam int NCMP   = (ADDRESS_MAX < MATCH_CHARS) ? ADDRESS_MAX : MATCH_CHARS;

    logic [NCMP-1:0] char_ok;
    logic            count_ok;

    // Per-character compare; character i sits in byte (len-1-i)
    for (genvar i = 0; i < NCMP; i++)
    begin : g_char
        logic [MATCH_LEN_W-1:0] sel;
        logic [7:0]             want;

        assign sel  = match_length - MATCH_LEN_W'(i + 1);
        assign want = 8'(match_address >> {sel, 3'b000});
        assign char_ok[i] = (MATCH_LEN_W'(i) >= match_length) || (store[i] == want);
    end

    assign count_ok = (CMP_W'(count) == CMP_W'(match_length));
    assign hit      = count_ok && (&char_ok);

endmodule

// ===== rtl/core/nsd_parse.sv =====
module nsd_parse #(
    parameter int ADDRESS_MAX = 8,
    parameter int PAYLOAD_MAX = 128
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  logic [7:0]                       rx_byte,
    input  logic [nsd_pkg::CFG_DATA_W-1:0]   match_address,
    input  logic [nsd_pkg::MATCH_LEN_W-1:0]  match_length,
    output nsd_pkg::nsd_result_t             res,
    output logic                             pay_we,
    output logic [$clog2(PAYLOAD_MAX)-1:0]   pay_addr,
    output logic [7:0]                       pay_data
);
    import nsd_pkg::*;

    localparam int IDX_MAX = (ADDRESS_MAX > PAYLOAD_MAX) ? ADDRESS_MAX : PAYLOAD_MAX;
    localparam int IDX_W   = $clog2(IDX_MAX);
    localparam int ACNT_W  = $clog2(ADDRESS_MAX);
    localparam int PADDR_W = $clog2(PAYLOAD_MAX);

    nsd_phase_t                  phase_reg, phase_next;
    logic [7:0]                  xor_reg, xor_next;
    logic [7:0]                  rsum_reg, rsum_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [ACNT_W-1:0]           acnt_reg, acnt_next;
    logic [COUNT_W-1:0]          total_reg, total_next;
    logic [ADDRESS_MAX-1:0][7:0] addr_store_reg;
    logic                        addr_we;
    logic [7:0]                  digit;
    logic [7:0]                  sum_full;
    logic                        emit;
    logic                        checked;
    logic                        hit;

    assign digit    = hex_value(rx_byte);
    assign sum_full = rsum_reg | digit;

    // Per-byte phase update
    always_comb
    begin
        phase_next = phase_reg;
        xor_next   = xor_reg;
        rsum_next  = rsum_reg;
        idx_next   = idx_reg;
        acnt_next  = acnt_reg;
        addr_we    = 1'b0;
        pay_we     = 1'b0;
        emit       = 1'b0;
        checked    = 1'b0;

        if (step)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == CH_DOLLAR)
                    begin
                        xor_next   = '0;
                        idx_next   = '0;
                        acnt_next  = '0;
                        phase_next = PH_ADDR;
                    end
                end
                PH_ADDR:
                begin
                    if (rx_byte == CH_COMMA)
                    begin
                        xor_next   = xor_reg ^ rx_byte;
                        acnt_next  = idx_reg[ACNT_W-1:0];
                        idx_next   = '0;
                        phase_next = PH_DATA;
                    end
                    else if (rx_byte == CH_STAR)
                    begin
                        acnt_next  = idx_reg[ACNT_W-1:0];
                        idx_next   = '0;
                        phase_next = PH_SUM1;
                    end
                    else
                    begin
                        addr_we  = 1'b1;
                        xor_next = xor_reg ^ rx_byte;
                        idx_next = idx_reg + IDX_W'(1);
                        // address overflow drops the sentence
                        if (idx_reg == IDX_W'(ADDRESS_MAX - 1))
                            phase_next = PH_HUNT;
                    end
                end
                PH_DATA:
                begin
                    if (rx_byte == CH_STAR)
                    begin
                        phase_next = PH_SUM1;
                    end
                    else if (rx_byte == CH_CR)
                    begin
                        emit       = 1'b1;
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        pay_we   = 1'b1;
                        xor_next = xor_reg ^ rx_byte;
                        idx_next = idx_reg + IDX_W'(1);
                        // payload overflow drops the sentence
                        if (idx_reg == IDX_W'(PAYLOAD_MAX - 1))
                            phase_next = PH_HUNT;
                    end
                end
                PH_SUM1:
                begin
                    rsum_next  = {digit[3:0], 4'b0000};
                    phase_next = PH_SUM2;
                end
                PH_SUM2:
                begin
                    rsum_next  = sum_full;
                    emit       = (sum_full == xor_reg);
                    checked    = 1'b1;
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end

        total_next = emit ? (total_reg + COUNT_W'(1)) : total_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            xor_reg   <= '0;
            rsum_reg  <= '0;
            idx_reg   <= '0;
            acnt_reg  <= '0;
            total_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            xor_reg   <= xor_next;
            rsum_reg  <= rsum_next;
            idx_reg   <= idx_next;
            acnt_reg  <= acnt_next;
            total_reg <= total_next;
        end
    end

    // Address characters, written only inside a sentence
    always_ff @(posedge clk)
    begin
        if (addr_we)
        begin
            addr_store_reg[idx_reg[ACNT_W-1:0]] <= rx_byte;
        end
    end

    nsd_match #(
        .ADDRESS_MAX (ADDRESS_MAX)
    ) u_match (
        .store         (addr_store_reg),
        .count         (acnt_reg),
        .match_address (match_address),
        .match_length  (match_length),
        .hit           (hit)
    );

    // Payload write request toward the buffer
    assign pay_addr = idx_reg[PADDR_W-1:0];
    assign pay_data = rx_byte;

    // Result of the sentence that ends with this byte
    always_comb
    begin
        res.emit             = emit;
        res.address_is_match = hit;
        res.address_length   = ADDR_LEN_W'(acnt_reg);
        res.payload_length   = PAY_LEN_W'(idx_reg);
        res.checksum_checked = checked;
        res.sentence_count   = total_reg + COUNT_W'(1);
    end

endmodule

// ===== rtl/core/nmea_sentence_deframer.sv =====
// NMEA sentence deframer. Takes one received character per request on rx and
// gives one request on result for each sentence accepted: at CR without a
// checksum, or at '*' plus two uppercase hex digits that equal the XOR of all
// bytes between '$' and '*'. Throughput is one character per clock while no
// result waits on result.ready; a character passes through the input register,
// is parsed, and result.valid comes from the result register. The parser also
// writes the payload buffer (one RAM write port). While a result waits on
// result.ready the parser holds: one more character can enter the input
// register, then rx.ready drops until the result is taken. The user must write
// match_address and match_length through cfg_* only while no sentence is
// pending; the block does not enforce this. No clearing pass follows reset.
module nmea_sentence_deframer #(
    parameter int ADDRESS_MAX = 8,
    parameter int PAYLOAD_MAX = 128
) (
    input  logic                              clk,
    input  logic                              rst_n,
    nsd_byte_if.sink                          rx,
    nsd_result_if.source                      result,
    input  logic                              cfg_we,
    input  logic [nsd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [nsd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import nsd_pkg::*;

    localparam int PADDR_W = $clog2(PAYLOAD_MAX);

    logic [CFG_DATA_W-1:0]  match_address_reg;
    logic [MATCH_LEN_W-1:0] match_length_reg;

    logic                   in_valid_reg, in_valid_next;
    logic [7:0]             in_byte_reg;
    logic                   advance;
    logic                   step;

    nsd_result_t            res;
    nsd_result_t            out_reg;
    logic                   out_valid_reg, out_valid_next;

    logic                   pay_we;
    logic [PADDR_W-1:0]     pay_addr;
    logic [7:0]             pay_data;
    logic [PADDR_W-1:0]     pay_last_reg;
    logic [7:0]             pay_rdata;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_address_reg <= MATCH_ADDRESS_RESET;
            match_length_reg  <= MATCH_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (nsd_cfg_idx_t'(cfg_index))
                CFG_MATCH_ADDRESS: match_address_reg <= cfg_data;
                CFG_MATCH_LENGTH:  match_length_reg  <= cfg_data[MATCH_LEN_W-1:0];
                default:           match_length_reg  <= match_length_reg;
            endcase
        end
    end

    // Handshake: the parse stage moves whenever the result slot can take a value
    assign advance  = !out_valid_reg || result.ready;
    assign rx.ready = !in_valid_reg || advance;
    assign step     = in_valid_reg && advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (rx.ready)
            in_valid_next = rx.valid;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = step && res.emit;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
            in_byte_reg <= rx.rx_byte;
    end

    nsd_parse #(
        .ADDRESS_MAX (ADDRESS_MAX),
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_parse (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .rx_byte       (in_byte_reg),
        .match_address (match_address_reg),
        .match_length  (match_length_reg),
        .res           (res),
        .pay_we        (pay_we),
        .pay_addr      (pay_addr),
        .pay_data      (pay_data)
    );

    // Payload buffer; read port follows the last written entry
    nsd_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_MAX)
    ) u_payload (
        .clk   (clk),
        .we    (pay_we),
        .waddr (pay_addr),
        .wdata (pay_data),
        .raddr (pay_last_reg),
        .rdata (pay_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (pay_we)
            pay_last_reg <= pay_addr;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step && res.emit)
            out_reg <= res;
    end

    assign result.valid            = out_valid_reg;
    assign result.address_is_match = out_reg.address_is_match;
    assign result.address_length   = out_reg.address_length;
    assign result.payload_length   = out_reg.payload_length;
    assign result.checksum_checked = out_reg.checksum_checked;
    assign result.sentence_count   = out_reg.sentence_count;

    // A stalled character stays put in the input register
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input register changed while stalled");

    // A matching address always has the configured length
    a_match_len: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.address_is_match
        |-> (result.address_length == ADDR_LEN_W'(match_length_reg)))
        else $error("address match with wrong length");

    // The payload byte just written reads back from the buffer
    a_pay_readback: assert property (@(posedge clk) disable iff (!rst_n)
        $past(pay_we, 2) |-> (pay_rdata == $past(pay_data, 2)))
        else $error("payload buffer readback mismatch");

endmodule
